// ===== sv/eight_bit_cpu_execute_unit_defines.svh =====
// assertion helpers shared by the execute unit
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_DEFINES_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EBCPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EBCPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ebcpu_pkg.sv =====
package ebcpu_pkg;

    // instruction opcodes
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_LDI  = 4'd3,
        OP_BEQZ = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_JR   = 4'd7,
        OP_SLC  = 4'd8,
        OP_SRC  = 4'd9,
        OP_LB   = 4'd10,
        OP_SB   = 4'd11
    } op_t;

    // status register bit positions
    localparam int FLAG_C = 4;
    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_Z = 0;

    localparam int STATUS_W = 5;

endpackage

// ===== sv/ebcpu_ram.sv =====
module ebcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read returning the old contents on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/eight_bit_cpu_execute_unit.sv =====
// Execute stage of an 8-bit machine: one decoded instruction per request on the slave
// stream, one result per instruction on the master stream, in order. An instruction can be
// accepted every cycle unless the master side stalls; register and data memory are read at
// the accepting edge, then the instruction executes; when the stage advances it writes back
// and loads an output register that decouples the master side. The 64 byte registers
// live in two copies of a synchronous RAM, one per read port, and the data bytes in a
// third; a write made in the same cycle as a read of that entry is forwarded, and per-entry
// valid bits make never-written entries read as zero after reset, so no clearing pass is
// needed. The status flags are kept in flip-flops and updated as each instruction retires.
`include "eight_bit_cpu_execute_unit_defines.svh"

module eight_bit_cpu_execute_unit #(
    parameter int REGISTER_COUNT = 64,
    parameter int DATA_DEPTH     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[3:0], reg_a[9:4], operand_b[15:10], instr_addr[31:16]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0], redirect[16], status_flags[21:17], written_value[29:22],
    // undefined_opcode[30], zero pad[31]
    output logic [31:0] m_tdata
);

    import ebcpu_pkg::*;

    localparam int RF_AW = $clog2(REGISTER_COUNT);
    localparam int DM_AW = $clog2(DATA_DEPTH);
    localparam logic [6:0] RF_LIMIT = 7'(REGISTER_COUNT);
    localparam logic [6:0] DM_LIMIT = 7'(DATA_DEPTH);

    // request fields
    logic [3:0]  in_op;
    logic [5:0]  in_ra;
    logic [5:0]  in_fb;
    logic [15:0] in_pc;
    logic        in_ra_ok;
    logic        in_fb_ok;
    logic        in_dm_ok;
    logic        accept;
    logic        s1_adv;

    assign in_op    = s_tdata[3:0];
    assign in_ra    = s_tdata[9:4];
    assign in_fb    = s_tdata[15:10];
    assign in_pc    = s_tdata[31:16];
    assign in_ra_ok = {1'b0, in_ra} < RF_LIMIT;
    assign in_fb_ok = {1'b0, in_fb} < RF_LIMIT;
    assign in_dm_ok = {1'b0, in_fb} < DM_LIMIT;

    // execute stage registers
    logic                      s1_valid_reg;
    logic [3:0]                s1_op_reg;
    logic [5:0]                s1_ra_reg;
    logic [5:0]                s1_fb_reg;
    logic [15:0]               s1_pc_reg;
    logic                      a_live_reg;
    logic                      b_live_reg;
    logic                      m_live_reg;
    logic                      rf_byp_en_reg;
    logic [5:0]                rf_byp_addr_reg;
    logic [7:0]                rf_byp_data_reg;
    logic                      dm_byp_en_reg;
    logic [5:0]                dm_byp_addr_reg;
    logic [7:0]                dm_byp_data_reg;
    logic [REGISTER_COUNT-1:0] rf_valid_reg;
    logic [DATA_DEPTH-1:0]     dm_valid_reg;
    logic [STATUS_W-1:0]       status_reg;

    // output register
    logic                out_valid_reg;
    logic [15:0]         out_next_pc_reg;
    logic                out_redirect_reg;
    logic [STATUS_W-1:0] out_flags_reg;
    logic [7:0]          out_written_reg;
    logic                out_undef_reg;

    // handshake: the execute stage moves on whenever the output register frees up
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // memory ports
    logic       rf_we;
    logic       dm_we;
    logic [7:0] rf_a_rdata;
    logic [7:0] rf_b_rdata;
    logic [7:0] dm_rdata;
    logic [7:0] ex_value;
    logic [7:0] opa;
    logic [7:0] opb;
    logic [7:0] opm;

    ebcpu_ram #(.WIDTH(8), .DEPTH(REGISTER_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s1_ra_reg[RF_AW-1:0]),
        .wdata (ex_value),
        .re    (accept),
        .raddr (in_ra[RF_AW-1:0]),
        .rdata (rf_a_rdata)
    );

    ebcpu_ram #(.WIDTH(8), .DEPTH(REGISTER_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s1_ra_reg[RF_AW-1:0]),
        .wdata (ex_value),
        .re    (accept),
        .raddr (in_fb[RF_AW-1:0]),
        .rdata (rf_b_rdata)
    );

    ebcpu_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_dm (
        .clk   (clk),
        .we    (dm_we),
        .waddr (s1_fb_reg[DM_AW-1:0]),
        .wdata (opa),
        .re    (accept),
        .raddr (in_fb[DM_AW-1:0]),
        .rdata (dm_rdata)
    );

    // operand select: same-cycle write forwarded, never-written entries read zero
    always_comb
    begin
        if (rf_byp_en_reg && (rf_byp_addr_reg == s1_ra_reg))
            opa = rf_byp_data_reg;
        else
            opa = a_live_reg ? rf_a_rdata : 8'h00;
        if (rf_byp_en_reg && (rf_byp_addr_reg == s1_fb_reg))
            opb = rf_byp_data_reg;
        else
            opb = b_live_reg ? rf_b_rdata : 8'h00;
        if (dm_byp_en_reg && (dm_byp_addr_reg == s1_fb_reg))
            opm = dm_byp_data_reg;
        else
            opm = m_live_reg ? dm_rdata : 8'h00;
    end

    // execute
    logic [15:0]         ex_next_pc;
    logic [15:0]         ex_seq_pc;
    logic                ex_redirect;
    logic [STATUS_W-1:0] ex_flags;
    logic [7:0]          ex_written;
    logic                ex_undef;
    logic                ex_rf_wr;
    logic                ex_dm_wr;
    logic                s1_ra_ok;
    logic                s1_dm_ok;

    assign ex_seq_pc = s1_pc_reg + 16'd1;
    assign s1_ra_ok  = {1'b0, s1_ra_reg} < RF_LIMIT;
    assign s1_dm_ok  = {1'b0, s1_fb_reg} < DM_LIMIT;

    always_comb
    begin
        logic [8:0]  sum;
        logic [15:0] prod;
        logic [15:0] rot_l;
        logic [15:0] rot_r;
        logic        ovf;
        sum   = {1'b0, opa} + {1'b0, opb};
        prod  = {8'h00, opa} * {8'h00, opb};
        rot_l = {opa, opa} << s1_fb_reg[2:0];
        rot_r = {opa, opa} >> s1_fb_reg[2:0];
        ovf   = 1'b0;

        ex_next_pc  = ex_seq_pc;
        ex_redirect = 1'b0;
        ex_flags    = status_reg;
        ex_value    = 8'h00;
        ex_undef    = 1'b0;
        ex_rf_wr    = 1'b0;
        ex_dm_wr    = 1'b0;

        unique case (s1_op_reg)
            OP_ADD:
            begin
                ex_value         = sum[7:0];
                ex_rf_wr         = 1'b1;
                ovf              = ~(opa[7] ^ opb[7]) & (opa[7] ^ sum[7]);
                ex_flags[FLAG_C] = sum[8];
                ex_flags[FLAG_V] = ovf;
                ex_flags[FLAG_S] = sum[7] ^ ovf;
            end
            OP_SUB:
            begin
                ex_value         = opa - opb;
                ex_rf_wr         = 1'b1;
                ovf              = (opa[7] ^ opb[7]) & (opa[7] ^ ex_value[7]);
                ex_flags[FLAG_V] = ovf;
                ex_flags[FLAG_S] = ex_value[7] ^ ovf;
            end
            OP_MUL:
            begin
                ex_value = prod[7:0];
                ex_rf_wr = 1'b1;
            end
            OP_LDI:
            begin
                ex_value = {{2{s1_fb_reg[5]}}, s1_fb_reg};
                ex_rf_wr = 1'b1;
            end
            OP_BEQZ:
            begin
                if (opa == 8'h00)
                begin
                    ex_next_pc  = ex_seq_pc + {{10{s1_fb_reg[5]}}, s1_fb_reg};
                    ex_redirect = 1'b1;
                end
            end
            OP_AND:
            begin
                ex_value = opa & opb;
                ex_rf_wr = 1'b1;
            end
            OP_OR:
            begin
                ex_value = opa | opb;
                ex_rf_wr = 1'b1;
            end
            OP_JR:
            begin
                ex_next_pc  = {opa, opb};
                ex_redirect = 1'b1;
            end
            OP_SLC:
            begin
                ex_value = rot_l[15:8];
                ex_rf_wr = 1'b1;
            end
            OP_SRC:
            begin
                ex_value = rot_r[7:0];
                ex_rf_wr = 1'b1;
            end
            OP_LB:
            begin
                ex_value = opm;
                ex_rf_wr = 1'b1;
            end
            OP_SB:
            begin
                ex_value = opa;
                ex_dm_wr = 1'b1;
            end
            default:
            begin
                ex_undef = 1'b1;
            end
        endcase

        // arithmetic, logic and rotates refresh N and Z
        if (s1_op_reg == OP_ADD || s1_op_reg == OP_SUB || s1_op_reg == OP_MUL ||
            s1_op_reg == OP_AND || s1_op_reg == OP_OR || s1_op_reg == OP_SLC ||
            s1_op_reg == OP_SRC)
        begin
            ex_flags[FLAG_N] = ex_value[7];
            ex_flags[FLAG_Z] = (ex_value == 8'h00);
        end

        ex_written = ex_value;
    end

    assign rf_we = s1_adv && ex_rf_wr && s1_ra_ok;
    assign dm_we = s1_adv && ex_dm_wr && s1_dm_ok;

    // pipeline control, valid bits, forwarding and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_byp_en_reg <= 1'b0;
            dm_byp_en_reg <= 1'b0;
            rf_valid_reg  <= '0;
            dm_valid_reg  <= '0;
            status_reg    <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (accept)
            begin
                rf_byp_en_reg <= rf_we;
                dm_byp_en_reg <= dm_we;
            end

            if (rf_we)
                rf_valid_reg[s1_ra_reg[RF_AW-1:0]] <= 1'b1;
            if (dm_we)
                dm_valid_reg[s1_fb_reg[DM_AW-1:0]] <= 1'b1;

            if (s1_adv)
                status_reg <= ex_flags;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= in_op;
            s1_ra_reg       <= in_ra;
            s1_fb_reg       <= in_fb;
            s1_pc_reg       <= in_pc;
            a_live_reg      <= in_ra_ok && rf_valid_reg[in_ra[RF_AW-1:0]];
            b_live_reg      <= in_fb_ok && rf_valid_reg[in_fb[RF_AW-1:0]];
            m_live_reg      <= in_dm_ok && dm_valid_reg[in_fb[DM_AW-1:0]];
            rf_byp_addr_reg <= s1_ra_reg;
            rf_byp_data_reg <= ex_value;
            dm_byp_addr_reg <= s1_fb_reg;
            dm_byp_data_reg <= opa;
        end
        if (s1_adv)
        begin
            out_next_pc_reg  <= ex_next_pc;
            out_redirect_reg <= ex_redirect;
            out_flags_reg    <= ex_flags;
            out_written_reg  <= ex_written;
            out_undef_reg    <= ex_undef;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_undef_reg, out_written_reg, out_flags_reg,
                       out_redirect_reg, out_next_pc_reg};

    // checks
    `EBCPU_ASSERT_NOW(a_ready_when_empty, !s1_valid_reg, s_tready,
        "input not ready while the execute stage is empty")
    `EBCPU_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_reg,
        "accepted instruction did not reach the execute stage")
    `EBCPU_ASSERT_NOW(a_undef_no_write, s1_valid_reg && ex_undef,
        !rf_we && !dm_we && !ex_redirect,
        "undefined opcode changed state")
    `EBCPU_ASSERT_NOW(a_seq_pc, s1_adv && !ex_redirect, ex_next_pc == ex_seq_pc,
        "sequential next address is not the following instruction")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ebcpu_pkg::*;

    // opcodes 12 to 15 decode to nothing
    localparam logic [3:0] OP_UNDEF_FIRST = 4'd12;
    localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int HOT_REGS      = 8;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_ROWS = 25;

    // one decoded instruction, laid out exactly as on s_tdata
    typedef struct packed {
        logic [15:0] instr_addr;
        logic [5:0]  operand_b;
        logic [5:0]  reg_a;
        logic [3:0]  operation;
    } instr_t;

    // one retired instruction, laid out as m_tdata[30:0]
    typedef struct packed {
        logic                undefined_opcode;
        logic [7:0]          written_value;
        logic [STATUS_W-1:0] status_flags;
        logic                redirect;
        logic [15:0]         next_pc;
    } retire_t;

    typedef struct {
        logic [3:0]  op;
        logic [5:0]  ra;
        logic [5:0]  fb;
        logic [15:0] pc;
        bit          typed;
        retire_t     want;
    } dir_row_t;

    // receiver stall styles
    typedef enum int {RX_OPEN, RX_COIN, RX_HOLD, RX_MOSTLY} rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // side channel: hand-typed result for the request on s_tdata
    bit      row_typed = 1'b0;
    retire_t row_want  = '0;

    // predictor state
    logic [7:0]          reg_file [64] = '{default: 8'h00};
    logic [7:0]          data_mem [64] = '{default: 8'h00};
    logic [STATUS_W-1:0] status        = '0;

    retire_t pending_retires [$];

    int cycle_count      = 0;
    int mismatch_count   = 0;
    int items_accepted   = 0;
    int results_checked  = 0;
    int undefined_issued = 0;
    int redirects_issued = 0;
    int burst_left       = 0;

    // columns: opcode, reg_a, operand_b, instr_addr, typed, result
    dir_row_t directed_table [DIRECTED_ROWS] = '{
        // all-zero instruction right after reset
        '{OP_ADD, 6'd0, 6'h00, 16'h0000, 1'b1, '{undefined_opcode: 1'b0, written_value: 8'h00,
            status_flags: 5'b00001, redirect: 1'b0, next_pc: 16'h0001}},
        // all-ones undefined instruction, pc wraps
        '{OP_UNDEF_LAST, 6'd63, 6'h3F, 16'hFFFF, 1'b1, '{undefined_opcode: 1'b1,
            written_value: 8'h00, status_flags: 5'b00001, redirect: 1'b0, next_pc: 16'h0000}},
        // most negative immediate
        '{OP_LDI, 6'd1, 6'h20, 16'hFFFE, 1'b1, '{undefined_opcode: 1'b0, written_value: 8'hE0,
            status_flags: 5'b00001, redirect: 1'b0, next_pc: 16'hFFFF}},
        // most positive immediate
        '{OP_LDI, 6'd2, 6'h1F, 16'h0003, 1'b1, '{undefined_opcode: 1'b0, written_value: 8'h1F,
            status_flags: 5'b00001, redirect: 1'b0, next_pc: 16'h0004}},
        // minus one into the last register
        '{OP_LDI, 6'd63, 6'h3F, 16'h0004, 1'b1, '{undefined_opcode: 1'b0, written_value: 8'hFF,
            status_flags: 5'b00001, redirect: 1'b0, next_pc: 16'h0005}},
        // carry out with negative result
        '{OP_ADD, 6'd1, 6'h01, 16'h0005, 1'b0, '0},
        '{OP_LDI, 6'd4, 6'h01, 16'h0006, 1'b0, '0},
        // rotate right by one gives 0x80
        '{OP_SRC, 6'd4, 6'h01, 16'h0007, 1'b0, '0},
        // signed overflow on subtract
        '{OP_SUB, 6'd4, 6'h02, 16'h0008, 1'b0, '0},
        '{OP_MUL, 6'd63, 6'h3F, 16'h0009, 1'b0, '0},
        '{OP_AND, 6'd63, 6'h01, 16'h000A, 1'b0, '0},
        '{OP_OR,  6'd2, 6'h01, 16'h000B, 1'b0, '0},
        // taken branches, backward with wrap and forward
        '{OP_BEQZ, 6'd0, 6'h20, 16'h0010, 1'b0, '0},
        '{OP_BEQZ, 6'd0, 6'h1F, 16'hFFFF, 1'b0, '0},
        // branch not taken
        '{OP_BEQZ, 6'd2, 6'h20, 16'h0012, 1'b0, '0},
        '{OP_JR,  6'd63, 6'h02, 16'h0013, 1'b0, '0},
        // rotate amounts zero and seven
        '{OP_SLC, 6'd1, 6'h00, 16'h0014, 1'b0, '0},
        '{OP_SLC, 6'd1, 6'h07, 16'h0015, 1'b0, '0},
        '{OP_SRC, 6'd2, 6'h3F, 16'h0016, 1'b0, '0},
        // stores to both ends of data memory
        '{OP_SB,  6'd1, 6'h3F, 16'h0017, 1'b0, '0},
        '{OP_SB,  6'd2, 6'h00, 16'h0018, 1'b0, '0},
        '{OP_LB,  6'd5, 6'h3F, 16'h0019, 1'b0, '0},
        // load of an address never stored to
        '{OP_LB,  6'd6, 6'h20, 16'h001A, 1'b0, '0},
        '{OP_UNDEF_FIRST, 6'd5, 6'h00, 16'h1234, 1'b0, '0},
        '{OP_SUB, 6'd0, 6'h00, 16'h1235, 1'b0, '0}
    };

    eight_bit_cpu_execute_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_retires.size());
            $display("eight_bit_cpu_execute_unit regression: fail");
            $finish;
        end
    end

    function automatic void set_neg_zero(input logic [7:0] r);
        status[FLAG_N] = r[7];
        status[FLAG_Z] = (r == 8'h00);
    endfunction

    function automatic void set_overflow(input logic v);
        status[FLAG_V] = v;
        status[FLAG_S] = status[FLAG_N] ^ v;
    endfunction

    // executes one instruction on the predictor state
    function automatic retire_t execute_instr(input instr_t ins);
        retire_t    res;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        logic [8:0] sum;
        logic [2:0] rot;
        bit         wr;
        res         = '0;
        res.next_pc = ins.instr_addr + 16'd1;
        a           = reg_file[ins.reg_a];
        b           = reg_file[ins.operand_b];
        rot         = ins.operand_b[2:0];
        r           = '0;
        wr          = 1'b1;
        unique case (ins.operation)
            OP_ADD:
            begin
                sum = {1'b0, a} + {1'b0, b};
                r = sum[7:0];
                status[FLAG_C] = sum[8];
                set_neg_zero(r);
                set_overflow(a[7] == b[7] && r[7] != a[7]);
            end
            OP_SUB:
            begin
                r = a - b;
                set_neg_zero(r);
                set_overflow(a[7] != b[7] && r[7] != a[7]);
            end
            OP_MUL:
            begin
                r = a * b;
                set_neg_zero(r);
            end
            OP_LDI:
                r = {{2{ins.operand_b[5]}}, ins.operand_b};
            OP_BEQZ:
            begin
                wr = 1'b0;
                if (a == 8'h00)
                begin
                    res.next_pc  = ins.instr_addr + 16'd1 + {{10{ins.operand_b[5]}}, ins.operand_b};
                    res.redirect = 1'b1;
                end
            end
            OP_AND:
            begin
                r = a & b;
                set_neg_zero(r);
            end
            OP_OR:
            begin
                r = a | b;
                set_neg_zero(r);
            end
            OP_JR:
            begin
                wr = 1'b0;
                res.next_pc  = {a, b};
                res.redirect = 1'b1;
            end
            OP_SLC:
            begin
                r = (a << rot) | (a >> (8 - rot));
                set_neg_zero(r);
            end
            OP_SRC:
            begin
                r = (a >> rot) | (a << (8 - rot));
                set_neg_zero(r);
            end
            OP_LB:
                r = data_mem[ins.operand_b];
            OP_SB:
            begin
                wr = 1'b0;
                data_mem[ins.operand_b] = a;
                res.written_value = a;
            end
            default:
            begin
                wr = 1'b0;
                res.undefined_opcode = 1'b1;
            end
        endcase
        if (wr)
        begin
            reg_file[ins.reg_a] = r;
            res.written_value   = r;
        end
        res.status_flags = status;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, field, got, want);
        mismatch_count++;
    endtask

    // request side: predict; result side: compare with the oldest prediction
    always @(posedge clk)
    begin
        instr_t  acc;
        retire_t want;
        retire_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                acc  = s_tdata;
                want = execute_instr(acc);
                if (row_typed)
                    want = row_want;
                pending_retires.push_back(want);
                items_accepted++;
                if (want.undefined_opcode)
                    undefined_issued++;
                if (want.redirect)
                    redirects_issued++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[30:0];
                if (pending_retires.size() == 0)
                begin
                    $display("unexpected result 0x%08h with nothing outstanding", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_retires.pop_front();
                    if (got.next_pc !== want.next_pc)
                        report_mismatch("next_pc", got.next_pc, want.next_pc);
                    if (got.redirect !== want.redirect)
                        report_mismatch("redirect", 16'(got.redirect), 16'(want.redirect));
                    if (got.status_flags !== want.status_flags)
                        report_mismatch("status_flags", 16'(got.status_flags),
                                        16'(want.status_flags));
                    if (got.written_value !== want.written_value)
                        report_mismatch("written_value", 16'(got.written_value),
                                        16'(want.written_value));
                    if (got.undefined_opcode !== want.undefined_opcode)
                        report_mismatch("undefined_opcode", 16'(got.undefined_opcode),
                                        16'(want.undefined_opcode));
                    results_checked++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        rx_mode_t mode;
        int       len;
        forever
        begin
            mode = rx_mode_t'($urandom_range(RX_OPEN, RX_MOSTLY));
            len  = (mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
            repeat (len)
            begin
                @(posedge clk);
                unique case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_HOLD:  m_tready <= 1'b0;
                    default:  m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // sends one request, opening a new burst after a random gap when due
    task automatic send_instr(input instr_t ins, input bit typed, input retire_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid  <= 1'b1;
        s_tdata   <= ins;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (!s_tready);
    endtask

    // holds off requests until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        do @(posedge clk); while (pending_retires.size() != 0);
        burst_left = 0;
    endtask

    function automatic instr_t random_instr();
        instr_t ins;
        if ($urandom_range(0, 99) < 8)
            ins.operation = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        else
            ins.operation = 4'($urandom_range(OP_ADD, OP_SB));
        // mostly a small register set so results feed later instructions
        ins.reg_a     = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, HOT_REGS - 1))
                                                   : 6'($urandom);
        ins.operand_b = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, HOT_REGS - 1))
                                                   : 6'($urandom);
        if ($urandom_range(0, 9) < 2)
            ins.instr_addr = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                                  : 16'($urandom_range(0, 3));
        else
            ins.instr_addr = 16'($urandom);
        return ins;
    endfunction

    // stimulus
    initial
    begin
        instr_t ins;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_table[i])
        begin
            ins = {directed_table[i].pc, directed_table[i].fb, directed_table[i].ra,
                   directed_table[i].op};
            send_instr(ins, directed_table[i].typed, directed_table[i].want);
        end
        wait_drained();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            send_instr(random_instr(), 1'b0, '0);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d instructions (%0d undefined, %0d redirects) over %0d cycles",
                 items_accepted, undefined_issued, redirects_issued, cycle_count);
        $display("checked %0d results against the predictor, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_retires.size() == 0)
            $display("eight_bit_cpu_execute_unit regression: pass");
        else
            $display("eight_bit_cpu_execute_unit regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ebcpu_pkg.sv
sv/ebcpu_ram.sv
sv/eight_bit_cpu_execute_unit.sv
tb/tb_top.sv
